// File: rtl/assert_macros.svh
// Assertion macros used by the checker file of this block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// File: rtl/fue_pkg.sv
// ----------------------------------------------------------------------------
// fue_pkg
// Types, codes and helpers shared by the form URL encoder modules.
// ----------------------------------------------------------------------------
package fue_pkg;

  localparam int unsigned QUEUE_DEPTH = 2;

  typedef enum logic [1:0] {
    ACT_DATA      = 2'd0,
    ACT_END_NAME  = 2'd1,
    ACT_END_VALUE = 2'd2,
    ACT_END_FORM  = 2'd3
  } action_e;

  // A plain kind emits one byte; a percent kind emits '%' and two hex digits.
  typedef enum logic {
    KIND_PLAIN = 1'b0,
    KIND_PCT   = 1'b1
  } kind_e;

  typedef struct packed {
    logic       amp;
    kind_e      kind;
    logic [7:0] value;
  } desc_t;

  localparam logic [7:0] CH_DOT     = 8'h2E;
  localparam logic [7:0] CH_DASH    = 8'h2D;
  localparam logic [7:0] CH_UNDER   = 8'h5F;
  localparam logic [7:0] CH_SPACE   = 8'h20;
  localparam logic [7:0] CH_PLUS    = 8'h2B;
  localparam logic [7:0] CH_PERCENT = 8'h25;
  localparam logic [7:0] CH_EQUALS  = 8'h3D;
  localparam logic [7:0] CH_AMP     = 8'h26;

  function automatic logic [7:0] hex_digit(input logic [3:0] nib);
    logic [7:0] r;
    if (nib < 4'd10) begin
      r = 8'h30 + {4'd0, nib};
    end else begin
      r = 8'h37 + {4'd0, nib};
    end
    return r;
  endfunction

  function automatic logic passes_plain(input logic [7:0] c);
    logic r;
    r = (c == CH_DOT) || (c == CH_DASH) || (c == CH_UNDER) ||
        (c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h5A) ||
        (c >= 8'h61 && c <= 8'h7A);
    return r;
  endfunction

endpackage

// File: rtl/fue_front.sv
// ----------------------------------------------------------------------------
// fue_front
// Accepts form items, tracks the pending '&' and classifies each data byte
// and end of name into an output descriptor for the back end.
// ----------------------------------------------------------------------------
module fue_front (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  logic [1:0]     action_i,
  input  logic [7:0]     data_byte_i,
  input  logic           q_full_i,
  output logic           push_o,
  output fue_pkg::desc_t push_desc_o
);

  logic amp_pending_q, amp_pending_d;
  logic accept;

  assign in_ready_o = !q_full_i;
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    amp_pending_d    = amp_pending_q;
    push_o           = 1'b0;
    push_desc_o.amp  = amp_pending_q;
    push_desc_o.kind = fue_pkg::KIND_PLAIN;
    push_desc_o.value = data_byte_i;
    unique case (fue_pkg::action_e'(action_i))
      fue_pkg::ACT_DATA: begin
        push_o = accept;
        if (data_byte_i == fue_pkg::CH_SPACE) begin
          push_desc_o.value = fue_pkg::CH_PLUS;
        end else if (!fue_pkg::passes_plain(data_byte_i)) begin
          push_desc_o.kind = fue_pkg::KIND_PCT;
        end
        if (accept) begin
          amp_pending_d = 1'b0;
        end
      end
      fue_pkg::ACT_END_NAME: begin
        push_o            = accept;
        push_desc_o.value = fue_pkg::CH_EQUALS;
        if (accept) begin
          amp_pending_d = 1'b0;
        end
      end
      fue_pkg::ACT_END_VALUE: begin
        if (accept) begin
          amp_pending_d = 1'b1;
        end
      end
      fue_pkg::ACT_END_FORM: begin
        if (accept) begin
          amp_pending_d = 1'b0;
        end
      end
      default: begin
        amp_pending_d = amp_pending_q;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      amp_pending_q <= 1'b0;
    end else begin
      amp_pending_q <= amp_pending_d;
    end
  end

endmodule

// File: rtl/fue_queue.sv
// ----------------------------------------------------------------------------
// fue_queue
// Small descriptor queue in flip-flops between the front and back ends.
// ----------------------------------------------------------------------------
module fue_queue #(
  parameter int unsigned DEPTH = fue_pkg::QUEUE_DEPTH
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  fue_pkg::desc_t push_desc_i,
  output logic           full_o,
  input  logic           pop_i,
  output logic           valid_o,
  output fue_pkg::desc_t head_o
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);

  fue_pkg::desc_t       slots_q [DEPTH];
  logic [PTR_W-1:0]     wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0]     count_q, count_d;
  logic                 do_push, do_pop;

  assign full_o  = (count_q == CNT_W'(DEPTH));
  assign valid_o = (count_q != '0);
  assign head_o  = slots_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slots_q[wr_ptr_q] <= push_desc_i;
    end
  end

endmodule

// File: rtl/fue_back.sv
// ----------------------------------------------------------------------------
// fue_back
// Holds one descriptor and serialises its bytes, one per cycle unless stalled.
// ----------------------------------------------------------------------------
module fue_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           q_valid_i,
  input  fue_pkg::desc_t q_head_i,
  output logic           pop_o,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output logic [7:0]     out_byte_o,
  output logic           last_of_run_o
);

  logic           cur_valid_q, cur_valid_d;
  fue_pkg::desc_t cur_q;
  logic [1:0]     phase_q, phase_d;
  logic [1:0]     last_idx;
  logic [1:0]     body_idx;
  logic           at_last;
  logic           advance;

  // The last index is the '&' prefix (if any) plus the body length less one.
  assign last_idx = {1'b0, cur_q.amp} + ((cur_q.kind == fue_pkg::KIND_PCT) ? 2'd2 : 2'd0);
  assign body_idx = phase_q - {1'b0, cur_q.amp};
  assign at_last  = (phase_q == last_idx);
  assign advance  = cur_valid_q && out_ready_i;

  assign out_valid_o   = cur_valid_q;
  assign last_of_run_o = at_last;

  always_comb begin
    if (cur_q.amp && phase_q == 2'd0) begin
      out_byte_o = fue_pkg::CH_AMP;
    end else if (cur_q.kind == fue_pkg::KIND_PLAIN) begin
      out_byte_o = cur_q.value;
    end else begin
      unique case (body_idx)
        2'd0:    out_byte_o = fue_pkg::CH_PERCENT;
        2'd1:    out_byte_o = fue_pkg::hex_digit(cur_q.value[7:4]);
        default: out_byte_o = fue_pkg::hex_digit(cur_q.value[3:0]);
      endcase
    end
  end

  // A new descriptor is loaded when the slot is empty or its final byte leaves.
  assign pop_o = q_valid_i && (!cur_valid_q || (advance && at_last));

  always_comb begin
    cur_valid_d = cur_valid_q;
    phase_d     = phase_q;
    if (pop_o) begin
      cur_valid_d = 1'b1;
      phase_d     = 2'd0;
    end else if (advance) begin
      if (at_last) begin
        cur_valid_d = 1'b0;
        phase_d     = 2'd0;
      end else begin
        phase_d = phase_q + 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_valid_q <= 1'b0;
      phase_q     <= 2'd0;
    end else begin
      cur_valid_q <= cur_valid_d;
      phase_q     <= phase_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      cur_q <= q_head_i;
    end
  end

endmodule

// File: rtl/form_url_encoder.sv
// ----------------------------------------------------------------------------
// form_url_encoder
// Encodes a stream of form items as application/x-www-form-urlencoded text.
// ----------------------------------------------------------------------------
// Input channel (in_valid_i/in_ready_o) carries one item: action_i selects a
// data byte, end of name, end of value or end of form; data_byte_i is used
// for data bytes only. Output channel (out_valid_o/out_ready_i) carries one
// encoded byte per cycle while out_ready_i is high, with last_of_run_o
// marking the final byte caused by an item. End of value and end of form
// produce no output. When the back end is idle, an accepted item is first
// written to the queue and then loaded into the back end's descriptor
// register before its first byte is offered. An item yields '=' or one
// plain byte, or a '%' and two hex digits for a percent-encoded byte, with
// a pending '&' going first; all of these leave through the single output
// byte lane.
// The queue between front and back lets the next items be accepted while
// earlier bytes are still being delivered; when the receiver stalls, the
// current byte is held and intake stops once the queue is full.
// Reset clears the pending '&', the queue and the output stage.
// ----------------------------------------------------------------------------
module form_url_encoder #(
  parameter int unsigned QUEUE_DEPTH = fue_pkg::QUEUE_DEPTH
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [1:0] action_i,
  input  logic [7:0] data_byte_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] out_byte_o,
  output logic       last_of_run_o
);

  logic           q_full, q_push, q_pop, q_valid;
  fue_pkg::desc_t push_desc, head_desc;

  fue_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .action_i    (action_i),
    .data_byte_i (data_byte_i),
    .q_full_i    (q_full),
    .push_o      (q_push),
    .push_desc_o (push_desc)
  );

  fue_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (q_push),
    .push_desc_i (push_desc),
    .full_o      (q_full),
    .pop_i       (q_pop),
    .valid_o     (q_valid),
    .head_o      (head_desc)
  );

  fue_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .q_valid_i     (q_valid),
    .q_head_i      (head_desc),
    .pop_o         (q_pop),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .out_byte_o    (out_byte_o),
    .last_of_run_o (last_of_run_o)
  );

endmodule

// File: rtl/fue_checker.sv
// ----------------------------------------------------------------------------
// fue_checker
// Port-level checks on the form URL encoder output stream.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module fue_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       out_valid_o,
  input logic       out_ready_i,
  input logic [7:0] out_byte_o,
  input logic       last_of_run_o
);

  logic out_fire;
  assign out_fire = out_valid_o && out_ready_i;

  // A stalled byte stays offered and unchanged.
  `ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && !out_ready_i, out_valid_o && $stable(out_byte_o) && $stable(last_of_run_o))

  // A separator '&' is always followed by the field byte that called for it.
  `ASSERT_IMPLY(a_amp_not_last, clk_i, rst_ni, out_fire && out_byte_o == fue_pkg::CH_AMP, !last_of_run_o)

  // A '%' always opens a three-byte escape.
  `ASSERT_IMPLY(a_pct_not_last, clk_i, rst_ni, out_fire && out_byte_o == fue_pkg::CH_PERCENT, !last_of_run_o)

  // A literal '=' only comes from an end of name and closes its run.
  `ASSERT_IMPLY(a_eq_last, clk_i, rst_ni, out_fire && out_byte_o == fue_pkg::CH_EQUALS, last_of_run_o)

endmodule

bind form_url_encoder fue_checker u_fue_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .out_valid_o   (out_valid_o),
  .out_ready_i   (out_ready_i),
  .out_byte_o    (out_byte_o),
  .last_of_run_o (last_of_run_o)
);

// File: tb/tb_form_url_encoder.sv
// ----------------------------------------------------------------------------
// tb_form_url_encoder
// Self-checking testbench for the form URL encoder. Items are sent on the
// input channel, and each one is encoded into a queue of expected output
// bytes. Every byte that leaves the block is compared with the head of that
// queue. The run covers directed corner cases, randomised forms under
// several idling patterns, and a long receiver hold-off that fills the block.
// ----------------------------------------------------------------------------
module tb_form_url_encoder;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned WATCHDOG_LIMIT = 2000;
  localparam int unsigned DRAIN_LIMIT    = 5000;
  localparam int unsigned TAIL_CYCLES    = 20;
  localparam int unsigned MAX_REPORTS    = 10;

  typedef struct packed {
    logic [7:0] ch;
    logic       last;
  } enc_byte_t;

  logic       clk_i       = 1'b0;
  logic       rst_ni      = 1'b0;
  logic       in_valid_i  = 1'b0;
  logic       in_ready_o;
  logic [1:0] action_i    = fue_pkg::ACT_DATA;
  logic [7:0] data_byte_i = 8'h00;
  logic       out_valid_o;
  logic       out_ready_i = 1'b0;
  logic [7:0] out_byte_o;
  logic       last_of_run_o;

  enc_byte_t   expected_q[$];
  logic        amp_armed     = 1'b0;
  int unsigned mismatches    = 0;
  int unsigned in_idle_pct   = 0;
  int unsigned out_stall_pct = 0;
  int unsigned hold_left     = 0;
  int unsigned quiet_cycles  = 0;

  form_url_encoder uut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .action_i     (action_i),
    .data_byte_i  (data_byte_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .out_byte_o   (out_byte_o),
    .last_of_run_o(last_of_run_o)
  );

  always #5 clk_i = ~clk_i;

  function automatic logic [7:0] hex_char(input logic [3:0] nib);
    if (nib > 4'd9) begin
      return 8'h41 + 8'(nib - 4'd10);
    end
    return 8'h30 + 8'(nib);
  endfunction

  function automatic logic is_unreserved(input logic [7:0] c);
    return (c == fue_pkg::CH_DOT) || (c == fue_pkg::CH_DASH) || (c == fue_pkg::CH_UNDER) ||
           (c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h5A) ||
           (c >= 8'h61 && c <= 8'h7A);
  endfunction

  // Encodes one accepted item and queues the bytes it should cause.
  function automatic void encode_item(input fue_pkg::action_e act, input logic [7:0] b);
    logic [7:0] run[$];
    run = {};
    case (act)
      fue_pkg::ACT_DATA, fue_pkg::ACT_END_NAME: begin
        if (amp_armed) begin
          run.push_back(fue_pkg::CH_AMP);
          amp_armed = 1'b0;
        end
        if (act == fue_pkg::ACT_END_NAME) begin
          run.push_back(fue_pkg::CH_EQUALS);
        end else if (b == fue_pkg::CH_SPACE) begin
          run.push_back(fue_pkg::CH_PLUS);
        end else if (is_unreserved(b)) begin
          run.push_back(b);
        end else begin
          run.push_back(fue_pkg::CH_PERCENT);
          run.push_back(hex_char(b[7:4]));
          run.push_back(hex_char(b[3:0]));
        end
      end
      fue_pkg::ACT_END_VALUE: amp_armed = 1'b1;
      default:                amp_armed = 1'b0;
    endcase
    foreach (run[i]) begin
      expected_q.push_back(enc_byte_t'{ch: run[i], last: (i == run.size() - 1)});
    end
  endfunction

  // Offers one item, after a random gap, and returns once it is accepted.
  task automatic send_item(input fue_pkg::action_e act, input logic [7:0] b);
    int unsigned gap;
    gap = 0;
    while ($urandom_range(99) < in_idle_pct) begin
      gap++;
    end
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    action_i    <= act;
    data_byte_i <= b;
    do begin
      @(posedge clk_i);
    end while (!(in_valid_i && in_ready_o));
    encode_item(act, b);
  endtask

  // Stops offering and waits for every queued byte to come out.
  task automatic wait_drained();
    int unsigned n;
    n = 0;
    in_valid_i <= 1'b0;
    while (expected_q.size() != 0 && n < DRAIN_LIMIT) begin
      @(posedge clk_i);
      n++;
    end
    repeat (TAIL_CYCLES) @(posedge clk_i);
  endtask

  function automatic logic [7:0] pick_byte();
    case ($urandom_range(4))
      0:       return 8'($urandom_range(8'h61, 8'h7A));
      1:       return 8'($urandom_range(8'h41, 8'h5A));
      2:       return 8'($urandom_range(8'h30, 8'h39));
      3: begin
        case ($urandom_range(3))
          0:       return fue_pkg::CH_SPACE;
          1:       return fue_pkg::CH_DOT;
          2:       return fue_pkg::CH_DASH;
          default: return fue_pkg::CH_UNDER;
        endcase
      end
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  task automatic send_field_part(input int unsigned len);
    repeat (len) send_item(fue_pkg::ACT_DATA, pick_byte());
  endtask

  task automatic test_directed();
    in_idle_pct   = 0;
    out_stall_pct = 0;
    send_item(fue_pkg::ACT_DATA, 8'h61);
    send_item(fue_pkg::ACT_DATA, 8'h7A);
    send_item(fue_pkg::ACT_DATA, 8'h41);
    send_item(fue_pkg::ACT_DATA, 8'h5A);
    send_item(fue_pkg::ACT_DATA, 8'h30);
    send_item(fue_pkg::ACT_DATA, 8'h39);
    send_item(fue_pkg::ACT_DATA, fue_pkg::CH_DOT);
    send_item(fue_pkg::ACT_DATA, fue_pkg::CH_DASH);
    send_item(fue_pkg::ACT_DATA, fue_pkg::CH_UNDER);
    send_item(fue_pkg::ACT_DATA, fue_pkg::CH_SPACE);
    send_item(fue_pkg::ACT_DATA, 8'h00);
    send_item(fue_pkg::ACT_DATA, 8'hFF);
    send_item(fue_pkg::ACT_DATA, 8'h80);
    send_item(fue_pkg::ACT_DATA, 8'h40);
    send_item(fue_pkg::ACT_DATA, 8'h7B);
    // Marks carry a data byte that must be ignored.
    send_item(fue_pkg::ACT_END_NAME, 8'hFF);
    send_item(fue_pkg::ACT_END_VALUE, 8'hFF);
    send_item(fue_pkg::ACT_END_VALUE, 8'h00);
    // An empty name after a finished field gives the ampersand and the equals.
    send_item(fue_pkg::ACT_END_NAME, 8'hA5);
    send_item(fue_pkg::ACT_END_VALUE, 8'h5A);
    send_item(fue_pkg::ACT_DATA, 8'h2F);
    send_item(fue_pkg::ACT_END_VALUE, 8'h00);
    // End of form drops the pending ampersand.
    send_item(fue_pkg::ACT_END_FORM, 8'hFF);
    send_item(fue_pkg::ACT_DATA, 8'h3A);
    send_item(fue_pkg::ACT_END_FORM, 8'h00);
    wait_drained();
  endtask

  task automatic test_random_forms(input int unsigned idle_pct, input int unsigned stall_pct,
                                   input int unsigned n_items);
    int unsigned sent;
    int unsigned fields;
    int unsigned name_len;
    int unsigned value_len;
    in_idle_pct   = idle_pct;
    out_stall_pct = stall_pct;
    sent = 0;
    while (sent < n_items) begin
      if ($urandom_range(99) < 15) begin
        send_item(fue_pkg::action_e'($urandom_range(3)), 8'($urandom_range(255)));
        sent++;
      end else begin
        fields = $urandom_range(1, 3);
        repeat (fields) begin
          name_len  = $urandom_range(0, 3);
          value_len = $urandom_range(0, 4);
          send_field_part(name_len);
          send_item(fue_pkg::ACT_END_NAME, 8'($urandom_range(255)));
          send_field_part(value_len);
          send_item(fue_pkg::ACT_END_VALUE, 8'($urandom_range(255)));
          sent += name_len + value_len + 2;
        end
        send_item(fue_pkg::ACT_END_FORM, 8'($urandom_range(255)));
        sent++;
      end
    end
    wait_drained();
  endtask

  // The receiver holds off while items keep coming, so intake must stall.
  task automatic test_backpressure();
    in_idle_pct   = 0;
    out_stall_pct = 0;
    hold_left     = 300;
    repeat (30) begin
      send_item(fue_pkg::ACT_DATA, 8'($urandom_range(8'h80, 8'hFF)));
    end
    send_item(fue_pkg::ACT_END_VALUE, 8'h00);
    send_item(fue_pkg::ACT_END_NAME, 8'h00);
    wait_drained();
  endtask

  always @(posedge clk_i) begin
    if (hold_left > 0) begin
      out_ready_i <= 1'b0;
      hold_left   <= hold_left - 1;
    end else begin
      out_ready_i <= ($urandom_range(99) >= out_stall_pct);
    end
  end

  always @(posedge clk_i) begin
    enc_byte_t exp_b;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS) begin
          $display("unexpected byte %02h last %0b", out_byte_o, last_of_run_o);
        end
      end else begin
        exp_b = expected_q.pop_front();
        if (out_byte_o !== exp_b.ch || last_of_run_o !== exp_b.last) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS) begin
            $display("mismatch: byte exp %02h got %02h, last exp %0b got %0b",
                     exp_b.ch, out_byte_o, exp_b.last, last_of_run_o);
          end
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles + 1 >= WATCHDOG_LIMIT) begin
        $display("watchdog: no item moved for %0d cycles", WATCHDOG_LIMIT);
        $display("RESULT: ERROR");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  initial begin
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_random_forms(0, 0, 100);
    test_random_forms(85, 0, 100);
    test_random_forms(0, 85, 100);
    test_random_forms(29, 29, 100);
    test_backpressure();
    if (mismatches == 0 && expected_q.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      if (expected_q.size() != 0) begin
        $display("%0d expected bytes never arrived", expected_q.size());
      end
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
